FILE: rtl/core/bmsc_pkg.sv
// ----------------------------------------------------------------------------
// bmsc_pkg
// Shared types and constants of the 2x2 square cover checker.
// ----------------------------------------------------------------------------
package bmsc_pkg;

  localparam int DIM_W  = 7;   // num_rows / num_cols register width
  localparam int POS_W  = 6;   // square_row / square_col width
  localparam int CNT_W  = 12;  // square_count width
  localparam int ADDR_W = 3;   // APB address width
  localparam int DATA_W = 32;  // APB data width

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

  // Register indexes, taken from paddr[2]
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic pix;
    logic cov;
  } cell_t;

  typedef struct packed {
    logic             is_verdict;
    logic [POS_W-1:0] square_row;
    logic [POS_W-1:0] square_col;
    logic             feasible;
    logic [CNT_W-1:0] square_count;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] push_cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

FILE: rtl/core/binary_mask_square_cover_check.sv
// ----------------------------------------------------------------------------
// binary_mask_square_cover_check
// Streams a binary image in raster order and covers its set pixels with
// 2x2 squares, reporting each square placed and a final feasibility verdict.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  pixel    | in        | pix_valid / pix_stall | pixel
//  result   | out       | res_valid / res_stall | is_verdict, square_row,
//           |           |                       | square_col, feasible,
//           |           |                       | square_count, last
//  config   | in / out  | APB (psel, penable)   | num_rows @0x0, num_cols @0x4
//
//  One pixel is accepted per cycle while pix_stall is low; its results enter
//  the output queue at the same edge and can leave on the next cycle. The line
//  buffer memory has one write port and one registered read, prefetched for the
//  next column. pix_stall rises only when the four-entry result queue has fewer
//  than two free slots, i.e. when the result side has been stalling.
//  Synchronous reset clears position, counters, flags and the queue; the
//  line buffer itself is never cleared (a row length count masks it).
// ----------------------------------------------------------------------------
module binary_mask_square_cover_check #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic                          pixel,
  // result output
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          is_verdict,
  output logic [bmsc_pkg::POS_W-1:0]    square_row,
  output logic [bmsc_pkg::POS_W-1:0]    square_col,
  output logic                          feasible,
  output logic [bmsc_pkg::CNT_W-1:0]    square_count,
  output logic                          last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bmsc_pkg::DATA_W-1:0]   pwdata,
  output logic [bmsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CDW = (CW + 1 > bmsc_pkg::DIM_W) ? CW + 1 : bmsc_pkg::DIM_W;
  localparam int RDW = (RW + 1 > bmsc_pkg::DIM_W) ? RW + 1 : bmsc_pkg::DIM_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bmsc_pkg::DIM_W-1:0] num_rows;
  logic [bmsc_pkg::DIM_W-1:0] num_cols;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= bmsc_pkg::DIM_RESET;
      num_cols <= bmsc_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bmsc_pkg::REG_NUM_ROWS: num_rows <= pwdata[bmsc_pkg::DIM_W-1:0];
        bmsc_pkg::REG_NUM_COLS: num_cols <= pwdata[bmsc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bmsc_pkg::REG_NUM_ROWS: prdata = bmsc_pkg::DATA_W'(num_rows);
      bmsc_pkg::REG_NUM_COLS: prdata = bmsc_pkg::DATA_W'(num_cols);
      default:                prdata = '0;
    endcase
  end

  // Effective dimensions: zero acts as one, oversize clamps to the maximum
  logic [CDW-1:0] cols_ext;
  logic [CDW-1:0] cols_eff;
  logic [RDW-1:0] rows_ext;
  logic [RDW-1:0] rows_eff;

  assign cols_ext = CDW'(num_cols);
  assign rows_ext = RDW'(num_rows);
  assign cols_eff = (cols_ext == '0)                ? CDW'(1) :
                    (cols_ext > CDW'(MAX_COLS))     ? CDW'(MAX_COLS) : cols_ext;
  assign rows_eff = (rows_ext == '0)                ? RDW'(1) :
                    (rows_ext > RDW'(MAX_ROWS))     ? RDW'(MAX_ROWS) : rows_ext;

  // --------------------------------------------------------------------------
  // Stream state
  // --------------------------------------------------------------------------
  logic [RW-1:0]              row_pos;
  logic [CW-1:0]              col_pos;
  logic [CW:0]                prev_len;      // valid cells of the previous row
  logic [bmsc_pkg::CNT_W-1:0] placed_total;
  logic                       fail_seen;
  logic                       cur_pend;      // uncovered cell of this row, fatal if it is the last
  bmsc_pkg::cell_t            cur_last;      // current row, column c-1
  bmsc_pkg::cell_t            prev_last;     // previous row, column c-1
  logic                       tail_pend;     // last cell of a row not yet stored
  logic [CW-1:0]              tail_addr;
  bmsc_pkg::cell_t            tail_data;
  logic                       fwd_hit;
  bmsc_pkg::cell_t            fwd_data;

  logic accept;
  logic room;

  assign pix_stall = !room;
  assign accept    = pix_valid && !pix_stall;

  // --------------------------------------------------------------------------
  // Line buffer: holds the previous row and is overwritten in place by the
  // current row one column behind the read point.
  // --------------------------------------------------------------------------
  logic            lb_we;
  logic [CW-1:0]   lb_wa;
  bmsc_pkg::cell_t lb_wd;
  logic [CW-1:0]   lb_ra;
  bmsc_pkg::cell_t lb_rd;

  bmsc_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line_buf (
    .clk (clk),
    .we  (lb_we),
    .wa  (lb_wa),
    .wd  (lb_wd),
    .ra  (lb_ra),
    .rd  (lb_rd)
  );

  // --------------------------------------------------------------------------
  // Window evaluation for the pixel at (row_pos, col_pos)
  // --------------------------------------------------------------------------
  bmsc_pkg::cell_t prev_raw;
  bmsc_pkg::cell_t prev_cur;
  logic            prev_ok;
  logic            has_left;
  logic            place;
  bmsc_pkg::cell_t pl_u;
  bmsc_pkg::cell_t pc_u;
  bmsc_pkg::cell_t cl_u;
  bmsc_pkg::cell_t cc_u;
  logic            end_row;
  logic            end_img;
  logic            fail_step;
  logic            pend_step;
  logic            fail_img;
  logic [bmsc_pkg::CNT_W-1:0] total_step;

  assign prev_raw = fwd_hit ? fwd_data : lb_rd;
  // cells past the previous row's length read as zero
  assign prev_ok  = {1'b0, col_pos} < prev_len;
  assign prev_cur = '{pix: prev_raw.pix & prev_ok, cov: prev_raw.cov & prev_ok};
  assign has_left = (col_pos != '0);

  // the current cell is always fresh, so a full window always places
  assign place = has_left && prev_last.pix && prev_cur.pix && cur_last.pix && pixel;

  assign pl_u = '{pix: prev_last.pix, cov: prev_last.cov | place};
  assign pc_u = '{pix: prev_cur.pix,  cov: prev_cur.cov  | place};
  assign cl_u = '{pix: cur_last.pix,  cov: cur_last.cov  | place};
  assign cc_u = '{pix: pixel,         cov: place};

  assign end_row = (CDW'(col_pos) + CDW'(1)) >= cols_eff;
  assign end_img = end_row && ((RDW'(row_pos) + RDW'(1)) >= rows_eff);

  // a previous-row cell is final once the window to its right is done
  assign fail_step = fail_seen
                   | (has_left & pl_u.pix & ~pl_u.cov)
                   | (end_row  & pc_u.pix & ~pc_u.cov);
  // current-row cells only count if this row turns out to be the last
  assign pend_step = cur_pend | (has_left & cl_u.pix & ~cl_u.cov);
  assign fail_img  = fail_step | pend_step | (cc_u.pix & ~cc_u.cov);

  assign total_step = placed_total + bmsc_pkg::CNT_W'(place);

  // --------------------------------------------------------------------------
  // Next position, line buffer write and read prefetch
  // --------------------------------------------------------------------------
  logic [CW-1:0]   col_next;
  logic            tail_pend_next;
  logic [CW-1:0]   tail_addr_next;
  bmsc_pkg::cell_t tail_data_next;

  always_comb begin
    col_next       = col_pos;
    tail_pend_next = tail_pend;
    tail_addr_next = tail_addr;
    tail_data_next = tail_data;
    if (accept) begin
      if (end_row) begin
        col_next = '0;
      end else begin
        col_next = CW'({1'b0, col_pos} + (CW + 1)'(1));
      end
      // a pending tail is written now; a row end that is not the image end
      // leaves its own last cell behind
      tail_pend_next = end_row && !end_img;
      tail_addr_next = col_pos;
      tail_data_next = cc_u;
    end
  end

  // pending tail only exists at column zero, where no left cell is stored
  assign lb_we = accept && (tail_pend || has_left);
  assign lb_wa = tail_pend ? tail_addr : CW'({1'b0, col_pos} - (CW + 1)'(1));
  assign lb_wd = tail_pend ? tail_data : cl_u;
  assign lb_ra = col_next;

  always_ff @(posedge clk) begin
    // forward whatever the memory does not yet hold at the prefetch address
    fwd_hit  <= (tail_pend_next && (tail_addr_next == col_next))
             || (lb_we && (lb_wa == col_next));
    fwd_data <= (tail_pend_next && (tail_addr_next == col_next)) ? tail_data_next
                                                                 : lb_wd;
    tail_addr <= tail_addr_next;
    tail_data <= tail_data_next;
    if (accept) begin
      cur_last  <= cc_u;
      prev_last <= pc_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos      <= '0;
      col_pos      <= '0;
      prev_len     <= '0;
      placed_total <= '0;
      fail_seen    <= 1'b0;
      cur_pend     <= 1'b0;
      tail_pend    <= 1'b0;
    end else begin
      tail_pend <= tail_pend_next;
      col_pos   <= col_next;
      if (accept) begin
        if (end_img) begin
          // drop the image and start over
          row_pos      <= '0;
          prev_len     <= '0;
          placed_total <= '0;
          fail_seen    <= 1'b0;
          cur_pend     <= 1'b0;
        end else if (end_row) begin
          row_pos      <= RW'({1'b0, row_pos} + (RW + 1)'(1));
          prev_len     <= {1'b0, col_pos} + (CW + 1)'(1);
          placed_total <= total_step;
          fail_seen    <= fail_step;
          cur_pend     <= 1'b0;
        end else begin
          placed_total <= total_step;
          fail_seen    <= fail_step;
          cur_pend     <= pend_step;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Results: square first, then the verdict on the last pixel
  // --------------------------------------------------------------------------
  bmsc_pkg::res_t  sq_res;
  bmsc_pkg::res_t  vd_res;
  bmsc_pkg::push_t push;
  bmsc_pkg::res_t  head;
  logic            head_valid;

  always_comb begin
    sq_res              = '0;
    sq_res.square_row   = bmsc_pkg::POS_W'(row_pos);
    sq_res.square_col   = bmsc_pkg::POS_W'(col_pos);

    vd_res              = '0;
    vd_res.is_verdict   = 1'b1;
    vd_res.feasible     = ~fail_img;
    vd_res.square_count = total_step;
    vd_res.last         = 1'b1;

    push.first    = place ? sq_res : vd_res;
    push.second   = vd_res;
    push.push_cnt = accept ? (2'(place) + 2'(end_img)) : 2'd0;
  end

  bmsc_res_fifo u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (!res_stall),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign res_valid    = head_valid;
  assign is_verdict   = head.is_verdict;
  assign square_row   = head.square_row;
  assign square_col   = head.square_col;
  assign feasible     = head.feasible;
  assign square_count = head.square_count;
  assign last         = head.last;

endmodule

FILE: rtl/core/bmsc_line_buf.sv
// ----------------------------------------------------------------------------
// bmsc_line_buf
// Line buffer of pixel / covered cells, one write port, registered read.
// ----------------------------------------------------------------------------
module bmsc_line_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   wa,
  input  bmsc_pkg::cell_t wd,
  input  logic [AW-1:0]   ra,
  output bmsc_pkg::cell_t rd
);

  bmsc_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read before write: the caller forwards same-address writes
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

FILE: rtl/core/bmsc_res_fifo.sv
// ----------------------------------------------------------------------------
// bmsc_res_fifo
// Small result queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module bmsc_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  bmsc_pkg::push_t     push,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output bmsc_pkg::res_t      head
);

  bmsc_pkg::res_t                ent [bmsc_pkg::QDEPTH];
  logic [bmsc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bmsc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bmsc_pkg::QPTR_W:0]     count;
  logic                          pop_ok;

  assign pop_ok     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head       = ent[rd_ptr];
  // keep space for the two items one input can produce
  assign room       = count <= (bmsc_pkg::QPTR_W + 1)'(bmsc_pkg::QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      ent[wr_ptr] <= push.first;
    end
    if (push.push_cnt == 2'd2) begin
      ent[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bmsc_pkg::QPTR_W'(push.push_cnt);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (bmsc_pkg::QPTR_W + 1)'(push.push_cnt)
                     - (bmsc_pkg::QPTR_W + 1)'(pop_ok);
    end
  end

endmodule
